FILE: rtl/core/gfm_pkg.sv
// gfm_pkg: types and constants shared by the GF(2^128) multiplier cells and top level.
// No dependencies.
`timescale 1ns / 1ps

package gfm_pkg;

    localparam int unsigned WordBits    = 64;
    localparam int unsigned ElemBits    = 128;
    localparam int unsigned WideBits    = 256;
    localparam int unsigned BitsPerCell = 8;
    localparam int unsigned MulCells    = ElemBits / BitsPerCell;
    localparam int unsigned FoldCells   = WordBits / BitsPerCell;
    localparam int unsigned NumCells    = MulCells + 2 * FoldCells;

    localparam logic [WordBits-1:0] PolyReset = 64'h0000_0000_0000_0087;

    typedef struct packed {
        logic [WordBits-1:0] a_low;
        logic [WordBits-1:0] a_high;
        logic [WordBits-1:0] b_low;
        logic [WordBits-1:0] b_high;
    } gfm_op_t;

    typedef struct packed {
        logic [WordBits-1:0] prod_low;
        logic [WordBits-1:0] prod_high;
    } gfm_res_t;

    // What travels down the cell chain for one item.
    typedef struct packed {
        logic [WideBits-1:0] acc;
        logic [WideBits-1:0] mcand;
        logic [ElemBits-1:0] mplier;
        logic [WordBits-1:0] poly;
    } gfm_lane_t;

endpackage

FILE: rtl/core/gfm_cell.sv
// gfm_cell: one carry-less multiply step of the chain, 8 multiplier bits per beat.
// Depends on gfm_pkg.
`timescale 1ns / 1ps

module gfm_cell
    import gfm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gfm_lane_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output gfm_lane_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    gfm_lane_t data_reg;
    gfm_lane_t data_next;
    logic      load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        logic [WideBits-1:0] part;
        part = '0;
        for (int j = 0; j < BitsPerCell; j++)
        begin
            if (in_data.mplier[j])
            begin
                part = part ^ (in_data.mcand << j);
            end
        end
        data_next.acc    = in_data.acc ^ part;
        data_next.mcand  = in_data.mcand << BitsPerCell;
        data_next.mplier = in_data.mplier >> BitsPerCell;
        data_next.poly   = in_data.poly;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/gf128_field_multiplier_top.sv
// gf128_field_multiplier_top: GF(2^128) multiplier built as a chain of 32 cells.
// Depends on gfm_pkg and gfm_cell.
`timescale 1ns / 1ps

// Usage:
//   op channel (op_valid/op_ready/op_data) takes operands a and b as 64-bit halves.
//   res channel (res_valid/res_ready/res_data) returns (a*b) mod (x^128 + P).
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes P, the low 64 terms of the
//   reduction polynomial; cfg_ready is always high. Write only while the chain is empty.
// Datapath: 16 cells form the 256-bit carry-less product, 8 bits of a per cell;
//   8 cells fold the upper half times P into the lower half; 8 more cells fold
//   the overflow of the first fold. Each cell is one register stage.
// Path: an accepted beat is registered in cell 0, then in each following cell in turn;
//   res_valid and res_data come from the register of the last cell.
// Throughput: one beat per cycle while res_ready stays high, set by the cell chain having one register per cell.
// Stall: each cell holds its beat while downstream is full; bubbles collapse, so
//   op_ready drops only when all 32 cells hold a beat. Up to 32 beats in flight.
// Reset: all cells empty, P = 0x87 (x^128 + x^7 + x^2 + x + 1).

module gf128_field_multiplier_top
    import gfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_ready,
    input  gfm_op_t             op_data,
    output logic                res_valid,
    input  logic                res_ready,
    output gfm_res_t            res_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WordBits-1:0] cfg_data
);

    logic [WordBits-1:0] poly_reg;
    logic [WordBits-1:0] poly_next;

    logic      cell_in_valid  [NumCells];
    logic      cell_in_ready  [NumCells];
    gfm_lane_t cell_in_data   [NumCells];
    logic      cell_out_valid [NumCells];
    logic      cell_out_ready [NumCells];
    gfm_lane_t cell_out_data  [NumCells];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        poly_next = poly_reg;
        if (cfg_valid)
        begin
            poly_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= PolyReset;
        end
        else
        begin
            poly_reg <= poly_next;
        end
    end

    for (genvar k = 0; k < NumCells; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign cell_in_valid[k]       = op_valid;
            assign cell_in_data[k].acc    = '0;
            assign cell_in_data[k].mcand  = {{(WideBits-ElemBits){1'b0}},
                                             op_data.b_high, op_data.b_low};
            assign cell_in_data[k].mplier = {op_data.a_high, op_data.a_low};
            assign cell_in_data[k].poly   = poly_reg;
        end
        else if (k == MulCells || k == MulCells + FoldCells)
        begin : g_fold
            // Fold: upper half times P into the lower half.
            assign cell_in_valid[k]       = cell_out_valid[k-1];
            assign cell_in_data[k].acc    = {{(WideBits-ElemBits){1'b0}},
                                             cell_out_data[k-1].acc[ElemBits-1:0]};
            assign cell_in_data[k].mcand  = {{(WideBits-ElemBits){1'b0}},
                                             cell_out_data[k-1].acc[WideBits-1:ElemBits]};
            assign cell_in_data[k].mplier = {{(ElemBits-WordBits){1'b0}},
                                             cell_out_data[k-1].poly};
            assign cell_in_data[k].poly   = cell_out_data[k-1].poly;
        end
        else
        begin : g_link
            assign cell_in_valid[k] = cell_out_valid[k-1];
            assign cell_in_data[k]  = cell_out_data[k-1];
        end

        if (k == NumCells - 1)
        begin : g_tail
            assign cell_out_ready[k] = res_ready;
        end
        else
        begin : g_mid
            assign cell_out_ready[k] = cell_in_ready[k+1];
        end

        gfm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_in_valid[k]),
            .in_ready  (cell_in_ready[k]),
            .in_data   (cell_in_data[k]),
            .out_valid (cell_out_valid[k]),
            .out_ready (cell_out_ready[k]),
            .out_data  (cell_out_data[k])
        );
    end

    assign op_ready           = cell_in_ready[0];
    assign res_valid          = cell_out_valid[NumCells-1];
    assign res_data.prod_low  = cell_out_data[NumCells-1].acc[WordBits-1:0];
    assign res_data.prod_high = cell_out_data[NumCells-1].acc[ElemBits-1:WordBits];

    // Second fold must leave nothing above bit 127.
    a_fully_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (cell_out_data[NumCells-1].acc[WideBits-1:ElemBits] == '0))
        else $error("reduction left bits above x^127");

    // Product cells must consume every multiplier bit.
    a_mplier_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        cell_out_valid[MulCells-1] |-> (cell_out_data[MulCells-1].mplier == '0))
        else $error("multiplier bits left after product cells");

    // Backpressure reaches the input only when the last cell is stalled.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !op_ready |-> (res_valid && !res_ready && cell_out_valid[0]))
        else $error("input stalled with room in the chain");

    // An accepted beat lands in the first cell.
    a_head_load: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && op_ready) |=> cell_out_valid[0])
        else $error("accepted beat not captured");

endmodule

FILE: tb/gfm_checker.sv
// gfm_checker: watches the op, res and cfg channels of the GF(2^128) multiplier,
// predicts each product and compares it with what comes out. Depends on gfm_pkg.
`timescale 1ns / 1ps

module gfm_checker
    import gfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    input  logic                op_ready,
    input  gfm_op_t             op_data,
    input  logic                res_valid,
    input  logic                res_ready,
    input  gfm_res_t            res_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [WordBits-1:0] cfg_data,
    output int                  errors,
    output int                  pending
);

    logic [WordBits-1:0] poly_shadow;
    gfm_res_t            expected_products[$];

    // Carry-less product of two 128-bit polynomials.
    function automatic logic [WideBits-1:0] clmul_wide(input logic [ElemBits-1:0] x,
                                                       input logic [ElemBits-1:0] y);
        logic [WideBits-1:0] acc;
        acc = '0;
        for (int i = 0; i < ElemBits; i++)
        begin
            if (x[i])
                acc ^= {{ElemBits{1'b0}}, y} << i;
        end
        return acc;
    endfunction

    // (a * b) mod (x^128 + p): fold the upper half times p, then fold the overflow.
    function automatic gfm_res_t field_product(input gfm_op_t op,
                                               input logic [WordBits-1:0] p);
        logic [WideBits-1:0] wide_prod;
        logic [WideBits-1:0] fold1;
        logic [WideBits-1:0] fold2;
        logic [ElemBits-1:0] rem;
        gfm_res_t            r;
        wide_prod = clmul_wide({op.a_high, op.a_low}, {op.b_high, op.b_low});
        fold1     = clmul_wide(wide_prod[WideBits-1:ElemBits], {{WordBits{1'b0}}, p});
        // overflow of the first fold is at most 63 bits, so fold2 fits in 128
        fold2     = clmul_wide(fold1[WideBits-1:ElemBits], {{WordBits{1'b0}}, p});
        rem       = wide_prod[ElemBits-1:0] ^ fold1[ElemBits-1:0] ^ fold2[ElemBits-1:0];
        r.prod_low  = rem[WordBits-1:0];
        r.prod_high = rem[ElemBits-1:WordBits];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gfm_res_t want;
        int       bad;
        int       delta;
        bad   = 0;
        delta = 0;
        if (!rst_n)
        begin
            poly_shadow <= PolyReset;
            expected_products.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                poly_shadow <= cfg_data;
            // pop before push so a beat never matches an item accepted the same edge
            if (res_valid && res_ready)
            begin
                if (expected_products.size() == 0)
                begin
                    $error("unexpected res beat: prod_low %h prod_high %h",
                           res_data.prod_low, res_data.prod_high);
                    bad++;
                end
                else
                begin
                    want = expected_products.pop_front();
                    delta--;
                    if (res_data.prod_low !== want.prod_low)
                    begin
                        $error("prod_low: expected %h, got %h",
                               want.prod_low, res_data.prod_low);
                        bad++;
                    end
                    if (res_data.prod_high !== want.prod_high)
                    begin
                        $error("prod_high: expected %h, got %h",
                               want.prod_high, res_data.prod_high);
                        bad++;
                    end
                end
            end
            if (op_valid && op_ready)
            begin
                expected_products.push_back(field_product(op_data, poly_shadow));
                delta++;
            end
            errors  <= errors + bad;
            pending <= pending + delta;
        end
    end

endmodule

FILE: tb/tb.sv
// tb: stimulus and verdict for gf128_field_multiplier_top; checking lives in gfm_checker.
// Depends on gfm_pkg, gf128_field_multiplier_top and gfm_checker.
`timescale 1ns / 1ps

module tb;
    import gfm_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int PhaseItems  = 100;
    localparam int NumPhases   = 5;
    localparam int NumDirected = 20;

    localparam logic [WordBits-1:0] AllOnes = {WordBits{1'b1}};
    localparam logic [WordBits-1:0] TopBit  = 64'h8000_0000_0000_0000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                op_valid  = 1'b0;
    logic                op_ready;
    gfm_op_t             op_data   = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    gfm_res_t            res_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [WordBits-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int cycles       = 0;
    bit tx_gaps_on   = 1'b1;
    bit rx_stalls_on = 1'b1;

    gf128_field_multiplier_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    gfm_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly no gap, sometimes a few cycles, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [WordBits-1:0] pick_word();
        logic [WordBits-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = AllOnes;
            2: w = 64'd1 << $urandom_range(0, WordBits - 1);
            3: w = ~(64'd1 << $urandom_range(0, WordBits - 1));
            default: ;
        endcase
        return w;
    endfunction

    // Plain multiply, squaring or 64-by-128 small product.
    function automatic gfm_op_t pick_op();
        gfm_op_t v;
        int      kind;
        v.a_low  = pick_word();
        v.a_high = pick_word();
        v.b_low  = pick_word();
        v.b_high = pick_word();
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            v.b_low  = v.a_low;
            v.b_high = v.a_high;
        end
        else if (kind < 4)
            v.a_high = '0;
        return v;
    endfunction

    task automatic send_op(input gfm_op_t v);
        int g;
        op_data  <= v;
        op_valid <= 1'b1;
        do
            @(posedge clk);
        while (!op_ready);
        g = tx_gaps_on ? pick_gap() : 0;
        if (g > 0)
        begin
            op_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected product has come back.
    task automatic drain();
        op_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_poly(input logic [WordBits-1:0] p);
        cfg_data  <= p;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: ready in random bursts with random stalls between them.
    initial
    begin
        int n;
        int g;
        forever
        begin
            n = $urandom_range(1, 20);
            res_ready <= 1'b1;
            repeat (n) @(posedge clk);
            g = rx_stalls_on ? pick_gap() : 0;
            if (g > 0)
            begin
                res_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    initial
    begin
        gfm_op_t             directed_ops[NumDirected];
        logic [WordBits-1:0] phase_polys[NumPhases];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset polynomial: identities, extremes, reduction of top terms
        directed_ops[0]  = '{a_low: '0, a_high: '0, b_low: '0, b_high: '0};
        directed_ops[1]  = '{a_low: AllOnes, a_high: AllOnes, b_low: AllOnes, b_high: AllOnes};
        directed_ops[2]  = '{a_low: 64'd1, a_high: '0,
                             b_low: 64'h0123_4567_89ab_cdef, b_high: 64'hfedc_ba98_7654_3210};
        directed_ops[3]  = '{a_low: '0, a_high: TopBit, b_low: 64'd2, b_high: '0};
        directed_ops[4]  = '{a_low: '0, a_high: TopBit, b_low: '0, b_high: TopBit};
        directed_ops[5]  = '{a_low: AllOnes, a_high: '0, b_low: AllOnes, b_high: AllOnes};
        directed_ops[6]  = '{a_low: AllOnes, a_high: AllOnes, b_low: '0, b_high: '0};
        directed_ops[7]  = '{a_low: '0, a_high: 64'd1, b_low: '0, b_high: 64'd1};
        directed_ops[8]  = '{a_low: 64'haaaa_aaaa_aaaa_aaaa, a_high: 64'h5555_5555_5555_5555,
                             b_low: 64'h5555_5555_5555_5555, b_high: 64'haaaa_aaaa_aaaa_aaaa};
        directed_ops[9]  = '{a_low: AllOnes, a_high: TopBit, b_low: AllOnes, b_high: TopBit};
        for (int i = 0; i < 10; i++)
            send_op(directed_ops[i]);
        drain();

        // zero polynomial gives the plain low half; all-ones polynomial maximizes overflow
        write_poly('0);
        for (int i = 1; i < 6; i++)
            send_op(directed_ops[i]);
        drain();
        write_poly(AllOnes);
        for (int i = 1; i < 6; i++)
            send_op(directed_ops[i]);
        drain();

        phase_polys[0] = '0;
        phase_polys[1] = AllOnes;
        phase_polys[2] = {$urandom, $urandom};
        phase_polys[3] = TopBit | 64'd1;
        phase_polys[4] = PolyReset;
        for (int ph = 0; ph < NumPhases; ph++)
        begin
            write_poly(phase_polys[ph]);
            // one phase runs flat out on both sides
            tx_gaps_on   = (ph != 2);
            rx_stalls_on = (ph != 2);
            for (int i = 0; i < PhaseItems; i++)
            begin
                if (ph == 3 && i == PhaseItems / 2)
                    drain();
                send_op(pick_op());
            end
            drain();
        end

        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/gfm_pkg.sv
rtl/core/gfm_cell.sv
rtl/core/gf128_field_multiplier_top.sv
tb/gfm_checker.sv
tb/tb.sv
